/* design/lcdns_pkg.sv */
// Shared types, constants and the power-up table for the display nibble sequencer.
package lcdns_pkg;

  // Request codes on the func field
  localparam logic [2:0] F_INIT   = 3'd0;
  localparam logic [2:0] F_CLEAR  = 3'd1;
  localparam logic [2:0] F_BEGIN  = 3'd2;
  localparam logic [2:0] F_CHAR   = 3'd3;
  localparam logic [2:0] F_GOTO   = 3'd4;
  localparam logic [2:0] F_BLINK  = 3'd5;
  localparam logic [2:0] F_CURSOR = 3'd6;

  // Register-select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Wait codes
  localparam logic [1:0] WAIT_NONE = 2'd0;

  localparam int CHARS_PER_LINE_DEF = 16;
  localparam int COL_W    = 5;   // column counter width
  localparam int JOB_NIBS = 6;   // longest non-init nibble list
  localparam int JOB_IW   = 3;   // index bits into that list
  localparam int PWR_LEN  = 14;  // power-up nibbles
  localparam int LEN_W    = 4;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;

  // Line base commands (upper and lower nibble)
  localparam logic [7:0] LINE1_BASE = 8'h80;
  localparam logic [7:0] LINE2_BASE = 8'hC0;

  // One queued job: either the power-up table or a short list of {rs, nibble}
  typedef struct packed {
    logic                         is_init;
    logic [LEN_W-1:0]             len;
    logic [JOB_NIBS-1:0][4:0]     nibs;
  } lcdns_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lcdns_qstat_t;

  function automatic logic [4:0] cmd_nib(input logic [3:0] n);
    return {RS_CMD, n};
  endfunction

  function automatic logic [4:0] data_nib(input logic [3:0] n);
    return {RS_DATA, n};
  endfunction

  // Power-up sequence nibbles
  function automatic logic [3:0] pwr_nib(input logic [LEN_W-1:0] i);
    logic [3:0] v;
    case (i)
      4'd0, 4'd1, 4'd2: v = 4'h3;
      4'd3, 4'd4:       v = 4'h2;
      4'd5, 4'd7:       v = 4'h8;
      4'd9:             v = 4'h1;
      4'd11:            v = 4'h6;
      4'd13:            v = 4'hF;
      default:          v = 4'h0;
    endcase
    return v;
  endfunction

  // Power-up sequence wait codes
  function automatic logic [1:0] pwr_wait(input logic [LEN_W-1:0] i);
    logic [1:0] v;
    case (i)
      4'd0:                          v = 2'd2;
      4'd5:                          v = 2'd3;
      4'd1, 4'd2, 4'd3, 4'd7, 4'd9,
      4'd11, 4'd13:                  v = 2'd1;
      default:                       v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/lcdns_if.sv */
// Valid/ready channel interfaces for requests and nibble strobes.
interface lcdns_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] arg_a;
  logic [7:0] arg_b;
  modport source (output valid, func, arg_a, arg_b, input ready);
  modport sink   (input valid, func, arg_a, arg_b, output ready);
endinterface

interface lcdns_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic [1:0] wait_code;
  logic       last;
  modport source (output valid, reg_select, nibble, wait_code, last, input ready);
  modport sink   (input valid, reg_select, nibble, wait_code, last, output ready);
endinterface

/* design/char_lcd_nibble_sequencer_unit.sv */
// Top level of the character display nibble sequencer.
// Usage:
//   in_ch  : request beats {func, arg_a, arg_b}, taken when valid && ready.
//   out_ch : nibble strobe beats {reg_select, nibble, wait_code, last}; last
//            marks the final strobe caused by one request.
// Each request becomes 0 to 14 strobes (power-up 14, begin message 6,
// wrapped character 4, most others 1 or 2). Requests with no strobes
// (dropped characters, bad row, func 7) are accepted but emit nothing.
// Path: the front end classifies a request and writes the queue on the request
// edge; the back end then loads its first strobe into the output register once
// earlier jobs have drained and out_ch is not stalled.
// Throughput: one strobe per cycle from the back end while out_ch is ready;
// the four-entry job queue lets requests keep arriving, one per cycle, while
// earlier jobs drain, until it is full.
// Reset (rst_n low, synchronous) empties the queue, clears the output valid
// and puts the cursor on line 1, column 0.
// When out_ch stalls the strobe holds; the queue fills and in_ch.ready drops
// once four jobs are waiting.
module char_lcd_nibble_sequencer_unit #(
  parameter int CHARS_PER_LINE = lcdns_pkg::CHARS_PER_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lcdns_in_if.sink    in_ch,
  lcdns_out_if.source out_ch
);
  import lcdns_pkg::*;

  logic         push, pop;
  lcdns_job_t   push_job, head;
  lcdns_qstat_t qstat;

  lcdns_front #(.CHARS_PER_LINE(CHARS_PER_LINE)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  lcdns_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  lcdns_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* design/lcdns_front.sv */
// Front end: accepts requests, tracks cursor line/column, builds nibble jobs.
module lcdns_front #(
  parameter int CHARS_PER_LINE = lcdns_pkg::CHARS_PER_LINE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  lcdns_in_if.sink               in_ch,
  input  lcdns_pkg::lcdns_qstat_t qstat,
  output logic                   push,
  output lcdns_pkg::lcdns_job_t  job
);
  import lcdns_pkg::*;

  localparam logic [COL_W-1:0] CPL = COL_W'(CHARS_PER_LINE);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             second_r, second_nxt;
  logic             accept;
  logic [7:0]       cmd;

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (job.len != '0);

  // Classify request into a nibble list and next cursor state
  always_comb begin
    job        = '0;
    col_nxt    = col_r;
    second_nxt = second_r;
    cmd        = '0;
    case (in_ch.func)
      F_INIT: begin
        job.is_init = 1'b1;
        job.len     = LEN_W'(PWR_LEN);
      end
      F_CLEAR: begin
        job.len     = LEN_W'(2);
        job.nibs[0] = cmd_nib(4'h0);
        job.nibs[1] = cmd_nib(4'h1);
      end
      F_BEGIN: begin
        job.len     = LEN_W'(6);
        job.nibs[0] = cmd_nib(4'h0);
        job.nibs[1] = cmd_nib(4'h1);
        job.nibs[2] = cmd_nib(LINE1_BASE[7:4]);
        job.nibs[3] = cmd_nib(4'h0);
        job.nibs[4] = (in_ch.arg_a == 8'd2) ? cmd_nib(LINE2_BASE[7:4])
                                            : cmd_nib(LINE1_BASE[7:4]);
        job.nibs[5] = cmd_nib(4'h0);
        col_nxt     = '0;
        second_nxt  = (in_ch.arg_a == 8'd2);
      end
      F_CHAR: begin
        if (col_r >= CPL) begin
          if (!second_r) begin
            // line 1 full: wrap to line 2 column 0, then the character
            job.len     = LEN_W'(4);
            job.nibs[0] = cmd_nib(LINE2_BASE[7:4]);
            job.nibs[1] = cmd_nib(4'h0);
            job.nibs[2] = data_nib(in_ch.arg_a[7:4]);
            job.nibs[3] = data_nib(in_ch.arg_a[3:0]);
            second_nxt  = 1'b1;
            col_nxt     = COL_W'(1);
          end
          // line 2 full: dropped, no job
        end else begin
          job.len     = LEN_W'(2);
          job.nibs[0] = data_nib(in_ch.arg_a[7:4]);
          job.nibs[1] = data_nib(in_ch.arg_a[3:0]);
          col_nxt     = col_r + COL_W'(1);
        end
      end
      F_GOTO: begin
        cmd = ((in_ch.arg_a == 8'd1) ? LINE1_BASE : LINE2_BASE) + in_ch.arg_b;
        if (in_ch.arg_a inside {8'd1, 8'd2}) begin
          job.len     = LEN_W'(2);
          job.nibs[0] = cmd_nib(cmd[7:4]);
          job.nibs[1] = cmd_nib(cmd[3:0]);
        end
      end
      F_BLINK, F_CURSOR: begin
        job.nibs[0] = cmd_nib(4'h0);
        if (in_ch.arg_a == 8'd0) begin
          job.len     = LEN_W'(2);
          job.nibs[1] = (in_ch.func == F_BLINK) ? cmd_nib(4'hE) : cmd_nib(4'hD);
        end else if (in_ch.arg_a == 8'd1) begin
          job.len     = LEN_W'(2);
          job.nibs[1] = cmd_nib(4'hF);
        end else begin
          job.len     = LEN_W'(1);
        end
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      second_r <= 1'b0;
    end else if (accept) begin
      col_r    <= col_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* design/lcdns_fifo.sv */
// Short job queue between front end and strobe sequencer.
module lcdns_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  lcdns_pkg::lcdns_job_t   push_job,
  input  logic                    pop,
  output lcdns_pkg::lcdns_job_t   head,
  output lcdns_pkg::lcdns_qstat_t qstat
);
  import lcdns_pkg::*;

  lcdns_job_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign head        = mem_r[rd_r];
  assign qstat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (Q_AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (Q_AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + Q_AW'(1);
      if (pop)  rd_r <= rd_r + Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

endmodule

/* design/lcdns_back.sv */
// Back end: steps through the head job, one nibble strobe per beat.
module lcdns_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lcdns_pkg::lcdns_job_t   head,
  input  lcdns_pkg::lcdns_qstat_t qstat,
  output logic                    pop,
  lcdns_out_if.source             out_ch
);
  import lcdns_pkg::*;

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic             rs_r;
  logic [3:0]       nib_r;
  logic [1:0]       wait_r;
  logic             last_r;
  logic             load, is_last;
  logic [4:0]       cur;
  logic [1:0]       cur_wait;

  assign load    = !qstat.empty && (!vld_r || out_ch.ready);
  assign is_last = (idx_r == head.len - LEN_W'(1));
  assign pop     = load && is_last;

  // Current nibble of the head job
  always_comb begin
    if (head.is_init) begin
      cur      = cmd_nib(pwr_nib(idx_r));
      cur_wait = pwr_wait(idx_r);
    end else begin
      cur      = head.nibs[idx_r[JOB_IW-1:0]];
      cur_wait = WAIT_NONE;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = is_last ? '0 : idx_r + LEN_W'(1);
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      rs_r   <= cur[4];
      nib_r  <= cur[3:0];
      wait_r <= cur_wait;
      last_r <= is_last;
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.reg_select = rs_r;
  assign out_ch.nibble     = nib_r;
  assign out_ch.wait_code  = wait_r;
  assign out_ch.last       = last_r;

endmodule

/* design/lcdns_checker.sv */
// Port-level checks for the nibble sequencer, bound to the top level.
module lcdns_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_rs,
  input logic [3:0] out_nibble,
  input logic [1:0] out_wait,
  input logic       out_last
);

  // A stalled strobe beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rs) && $stable(out_nibble)
      && $stable(out_wait) && $stable(out_last))
    else $error("stalled strobe changed");

  // Reset leaves no strobe pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe valid after reset");

  // Data strobes never carry a wait
  a_data_nowait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rs |-> out_wait == 2'd0)
    else $error("data strobe with wait");

  // Wait code 3 only follows the function-set nibble mid power-up
  a_long_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait == 2'd3 |-> out_nibble == 4'h8 && !out_last && !out_rs)
    else $error("unexpected long wait strobe");

endmodule

bind char_lcd_nibble_sequencer_unit lcdns_checker u_lcdns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_rs     (out_ch.reg_select),
  .out_nibble (out_ch.nibble),
  .out_wait   (out_ch.wait_code),
  .out_last   (out_ch.last)
);

/* sim/lcdns_strobe_checker.sv */
// Watches request and strobe beats, predicts the strobe stream and counts mismatches.
module lcdns_strobe_checker (
  input  logic clk,
  input  logic rst_n,
  lcdns_in_if  req_mon,
  lcdns_out_if strobe_mon,
  output int   err_count,
  output int   pending
);
  import lcdns_pkg::*;

  // Line numbers and on/off status values carried on arg_a
  localparam logic [7:0] LINE_ONE = 8'd1;
  localparam logic [7:0] LINE_TWO = 8'd2;
  localparam logic [7:0] STAT_OFF = 8'd0;
  localparam logic [7:0] STAT_ON  = 8'd1;
  localparam int         MAX_REPORTS = 10;

  // Power-up nibbles and waits, first entry in the top bits
  localparam logic [4*PWR_LEN-1:0] PWR_NIBS  = 56'h3332280801060F;
  localparam logic [2*PWR_LEN-1:0] PWR_WAITS = {2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd3, 2'd0,
                                                2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1};

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic [1:0] wt;
    logic       last;
  } strobe_t;

  strobe_t          exp_strobes[$];
  strobe_t          held;
  logic             have_held = 1'b0;
  logic [COL_W-1:0] col_count = '0;
  logic             on_line2 = 1'b0;
  int               n_fail = 0;
  int               fail_seen = 0;
  int               depth_seen = 0;
  strobe_t          got;
  strobe_t          want;

  assign err_count = fail_seen;
  assign pending   = depth_seen;

  // Stage one strobe; the previous one is known not to be the last
  task automatic add_strobe(input logic rs, input logic [3:0] nib, input logic [1:0] wt);
    if (have_held) exp_strobes.push_back(held);
    held      = {rs, nib, wt, 1'b0};
    have_held = 1'b1;
  endtask

  // Expected strobes of one request, with the cursor state update
  task automatic predict_strobes(input logic [2:0] f, input logic [7:0] a,
                                 input logic [7:0] b);
    logic [7:0] cmd;
    case (f)
      F_INIT: begin
        for (int k = 0; k < PWR_LEN; k++) begin
          add_strobe(RS_CMD, PWR_NIBS[4*(PWR_LEN-1-k) +: 4], PWR_WAITS[2*(PWR_LEN-1-k) +: 2]);
        end
      end
      F_CLEAR: begin
        add_strobe(RS_CMD, 4'h0, WAIT_NONE);
        add_strobe(RS_CMD, 4'h1, WAIT_NONE);
      end
      F_BEGIN: begin
        add_strobe(RS_CMD, 4'h0, WAIT_NONE);
        add_strobe(RS_CMD, 4'h1, WAIT_NONE);
        add_strobe(RS_CMD, LINE1_BASE[7:4], WAIT_NONE);
        add_strobe(RS_CMD, LINE1_BASE[3:0], WAIT_NONE);
        // anything but line two lands on line one
        if (a == LINE_TWO) begin
          add_strobe(RS_CMD, LINE2_BASE[7:4], WAIT_NONE);
          on_line2 = 1'b1;
        end else begin
          add_strobe(RS_CMD, LINE1_BASE[7:4], WAIT_NONE);
          on_line2 = 1'b0;
        end
        add_strobe(RS_CMD, 4'h0, WAIT_NONE);
        col_count = '0;
      end
      F_CHAR: begin
        // full second line drops the character
        if (!(col_count >= CHARS_PER_LINE_DEF && on_line2)) begin
          if (col_count >= CHARS_PER_LINE_DEF) begin
            add_strobe(RS_CMD, LINE2_BASE[7:4], WAIT_NONE);
            add_strobe(RS_CMD, LINE2_BASE[3:0], WAIT_NONE);
            on_line2  = 1'b1;
            col_count = '0;
          end
          add_strobe(RS_DATA, a[7:4], WAIT_NONE);
          add_strobe(RS_DATA, a[3:0], WAIT_NONE);
          col_count = col_count + 1'b1;
        end
      end
      F_GOTO: begin
        if (a == LINE_ONE || a == LINE_TWO) begin
          cmd = ((a == LINE_ONE) ? LINE1_BASE : LINE2_BASE) + b;
          add_strobe(RS_CMD, cmd[7:4], WAIT_NONE);
          add_strobe(RS_CMD, cmd[3:0], WAIT_NONE);
        end
      end
      F_BLINK, F_CURSOR: begin
        add_strobe(RS_CMD, 4'h0, WAIT_NONE);
        if (a == STAT_OFF) add_strobe(RS_CMD, (f == F_BLINK) ? 4'hE : 4'hD, WAIT_NONE);
        else if (a == STAT_ON) add_strobe(RS_CMD, 4'hF, WAIT_NONE);
      end
      default: ;
    endcase
    if (have_held) begin
      held.last = 1'b1;
      exp_strobes.push_back(held);
      have_held = 1'b0;
    end
  endtask

  // Compare strobe beats first, then queue what a new request will cause
  always @(posedge clk) begin
    if (rst_n) begin
      if (strobe_mon.valid && strobe_mon.ready) begin
        got = {strobe_mon.reg_select, strobe_mon.nibble, strobe_mon.wait_code, strobe_mon.last};
        if (exp_strobes.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected strobe rs=%0d nibble=%h wait=%0d last=%0d",
                     $time, got.rs, got.nib, got.wt, got.last);
        end else begin
          want = exp_strobes.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("%0t: strobe mismatch exp rs=%0d nibble=%h wait=%0d last=%0d, got rs=%0d nibble=%h wait=%0d last=%0d",
                       $time, want.rs, want.nib, want.wt, want.last,
                       got.rs, got.nib, got.wt, got.last);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        predict_strobes(req_mon.func, req_mon.arg_a, req_mon.arg_b);
    end
    fail_seen  <= n_fail;
    depth_seen <= exp_strobes.size();
  end

endmodule

/* sim/tb_char_lcd_nibble_sequencer_unit.sv */
// Top of the nibble sequencer regression: clock, reset, request stimulus and verdict.
module tb_char_lcd_nibble_sequencer_unit;
  import lcdns_pkg::*;

  localparam int         LIMIT_CYCLES = 400000;
  localparam int         PHASE_ITEMS  = 95;
  localparam int         TAIL_CYCLES  = 20;
  localparam logic [2:0] F_UNUSED     = 3'd7;
  localparam logic [7:0] LINE_ONE     = 8'd1;
  localparam logic [7:0] LINE_TWO     = 8'd2;
  localparam logic [7:0] STAT_OFF     = 8'd0;
  localparam logic [7:0] STAT_ON      = 8'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic recv_ready = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   items_sent = 0;
  int   cycles = 0;
  int   fail_count;
  int   strobes_due;

  lcdns_in_if  in_ch ();
  lcdns_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  char_lcd_nibble_sequencer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcdns_strobe_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .strobe_mon (out_ch),
    .err_count  (fail_count),
    .pending    (strobes_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    recv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("char_lcd_nibble_sequencer_unit regression: fail");
      $finish;
    end
  end

  // One request beat, with random idle cycles ahead of it
  task automatic send_req(input logic [2:0] f, input logic [7:0] a, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.func  = 3'($urandom);
      in_ch.arg_a = 8'($urandom);
      in_ch.arg_b = 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func  = f;
    in_ch.arg_a = a;
    in_ch.arg_b = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (f != F_UNUSED) items_sent++;
  endtask

  // Mostly valid line numbers or status values, sometimes any byte
  function automatic logic [7:0] pick_line();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return ($urandom_range(1) == 0) ? LINE_ONE : LINE_TWO;
  endfunction

  function automatic logic [7:0] pick_status();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return ($urandom_range(1) == 0) ? STAT_OFF : STAT_ON;
  endfunction

  task automatic send_random_req();
    logic [2:0] f;
    logic [7:0] a;
    f = 3'($urandom_range(7));
    case (f)
      F_BEGIN, F_GOTO:   a = pick_line();
      F_BLINK, F_CURSOR: a = pick_status();
      default:           a = 8'($urandom);
    endcase
    send_req(f, a, 8'($urandom));
  endtask

  // Begin message then a run of characters, optionally with stray requests mixed in
  task automatic send_message(input logic [7:0] line, input int n_chars, input bit noisy);
    send_req(F_BEGIN, line, 8'($urandom));
    for (int i = 0; i < n_chars; i++) begin
      if (noisy && $urandom_range(19) == 0) send_random_req();
      send_req(F_CHAR, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int quota_end;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    quota_end      = items_sent + PHASE_ITEMS;
    while (items_sent < quota_end) begin
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(1) == 0) send_message(pick_line(), $urandom_range(20), 1'b1);
        else send_message(pick_line(), $urandom_range(40, 14), 1'b1);
      end else begin
        send_random_req();
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func  = F_INIT;
    in_ch.arg_a = 8'h00;
    in_ch.arg_b = 8'h00;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every request kind, field extremes, odd lines, rows and status values
    send_req(F_INIT,   8'h00, 8'h00);
    send_req(F_CLEAR,  8'hFF, 8'hFF);
    send_req(F_BEGIN,  LINE_ONE, 8'h00);
    send_req(F_CHAR,   8'h00, 8'h00);
    send_req(F_CHAR,   8'hFF, 8'hFF);
    send_req(F_CHAR,   8'h5A, 8'hA5);
    send_req(F_BEGIN,  LINE_TWO, 8'hFF);
    send_req(F_CHAR,   8'hA5, 8'h5A);
    send_req(F_BEGIN,  8'h00, 8'h00);
    send_req(F_BEGIN,  8'hFF, 8'hFF);
    send_req(F_GOTO,   LINE_ONE, 8'h00);
    send_req(F_GOTO,   LINE_TWO, 8'hFF);
    send_req(F_GOTO,   LINE_ONE, 8'h7F);
    send_req(F_GOTO,   LINE_TWO, 8'h40);
    send_req(F_GOTO,   8'h00, 8'h03);
    send_req(F_GOTO,   8'hFF, 8'h03);
    send_req(F_BLINK,  STAT_OFF, 8'h00);
    send_req(F_BLINK,  STAT_ON, 8'hFF);
    send_req(F_BLINK,  8'h02, 8'h00);
    send_req(F_BLINK,  8'hFF, 8'h00);
    send_req(F_CURSOR, STAT_OFF, 8'h00);
    send_req(F_CURSOR, STAT_ON, 8'h00);
    send_req(F_CURSOR, 8'h80, 8'h00);
    send_req(F_UNUSED, 8'hFF, 8'hFF);

    // Fill line one, wrap to line two, then run past its end
    send_message(LINE_ONE, 36, 1'b0);

    run_phase(0, 0);
    run_phase(52, 0);
    run_phase(0, 52);
    run_phase(37, 37);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (strobes_due != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("char_lcd_nibble_sequencer_unit regression: pass");
    end else begin
      $display("char_lcd_nibble_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule
